>>> rtl/flpm_pkg.sv
// Shared types, constants and helpers for the filtered Lehmer pair match counter.
// Used by flpm_gen, the core top level and the checker.
`timescale 1ns / 1ps

package flpm_pkg;

    localparam int VALUE_W    = 31;
    localparam int MASK_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MULT_BITS  = 16;

    localparam int COMPARE_BITS_DEFAULT = 16;

    localparam logic [VALUE_W-1:0]   MODULUS   = 31'h7FFF_FFFF;
    localparam logic [MULT_BITS-1:0] MULT_A    = 16'd16807;
    localparam logic [MULT_BITS-1:0] MULT_B    = 16'd48271;
    localparam logic [COUNT_W-1:0]   COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [VALUE_W-1:0] SEED_RESET        = 31'd1;
    localparam logic [MASK_W-1:0]  MASK_RESET        = 8'd0;
    localparam logic [COUNT_W-1:0] ROUND_TOTAL_RESET = 32'd40000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_A        = 3'd0,
        CFG_SEED_B        = 3'd1,
        CFG_FILTER_MASK_A = 3'd2,
        CFG_FILTER_MASK_B = 3'd3,
        CFG_ROUND_TOTAL   = 3'd4
    } cfg_index_t;

    // Round start request from the core to one generator.
    typedef struct packed {
        logic start;
        logic load;
    } gen_ctrl_t;

    // The modulus itself is congruent to zero.
    function automatic logic [VALUE_W-1:0] load_seed(input logic [VALUE_W-1:0] s);
        begin
            load_seed = (s == MODULUS) ? '0 : s;
        end
    endfunction

endpackage

>>> rtl/filtered_lehmer_pair_match_counter_core.sv
// Top level of the filtered Lehmer pair match counter: config registers, round
// control, match and round counters, result register. Depends on flpm_pkg, flpm_gen.
`timescale 1ns / 1ps

// Each accepted item runs one round of two MINSTD generators (x16807 and x48271
// modulo 2^31-1). Every generator step is a bit-serial modular multiply, one
// multiplier bit per cycle, and a generator keeps stepping while its value AND
// its filter mask is nonzero. A round lasts for N generator steps, where N is the
// larger of the two step counts (N is 1 with zero masks, about 8 with mask 7), and
// ends only once the result register is free. One round is in flight at a time;
// a finished result sits in the output register while the next item is taken.
// Seeds are loaded by reset or by an item with restart set; masks and round_total
// act at once. Write config only while the block is idle.
module filtered_lehmer_pair_match_counter_core #(
    parameter int COMPARE_BITS = flpm_pkg::COMPARE_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [flpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [flpm_pkg::VALUE_W-1:0]    m_value_a,
    output logic [flpm_pkg::VALUE_W-1:0]    m_value_b,
    output logic                            m_low_match,
    output logic [flpm_pkg::COUNT_W-1:0]    m_match_count,
    output logic                            m_final_round
);
    import flpm_pkg::*;

    localparam logic [VALUE_W-1:0] CMP_MASK = VALUE_W'((64'd1 << COMPARE_BITS) - 64'd1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t             state_reg;
    logic [VALUE_W-1:0] seed_a_reg;
    logic [VALUE_W-1:0] seed_b_reg;
    logic [MASK_W-1:0]  mask_a_reg;
    logic [MASK_W-1:0]  mask_b_reg;
    logic [COUNT_W-1:0] round_total_reg;
    logic [COUNT_W-1:0] matches_reg;
    logic [COUNT_W-1:0] rounds_reg;

    logic               m_valid_reg;
    logic [VALUE_W-1:0] value_a_reg;
    logic [VALUE_W-1:0] value_b_reg;
    logic               low_match_reg;
    logic [COUNT_W-1:0] match_count_reg;
    logic               final_round_reg;

    gen_ctrl_t          gen_ctrl;
    logic               idle_a;
    logic               idle_b;
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;

    logic               in_take;
    logic               round_end;
    logic               match;
    logic [COUNT_W-1:0] matches_next;
    logic [COUNT_W-1:0] rounds_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_take = s_valid && s_ready;

    assign gen_ctrl.start = in_take;
    assign gen_ctrl.load  = s_restart;

    flpm_gen #(.MULT(MULT_A)) u_gen_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (gen_ctrl),
        .seed    (seed_a_reg),
        .mask    (mask_a_reg),
        .idle    (idle_a),
        .value   (value_a)
    );

    flpm_gen #(.MULT(MULT_B)) u_gen_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (gen_ctrl),
        .seed    (seed_b_reg),
        .mask    (mask_b_reg),
        .idle    (idle_b),
        .value   (value_b)
    );

    // hold the round until both generators finish and the result register is free
    assign round_end = (state_reg == ST_RUN) && idle_a && idle_b
                     && (!m_valid_reg || m_ready);

    always_comb begin
        match        = (((value_a ^ value_b) & CMP_MASK) == '0);
        matches_next = (match && (matches_reg != COUNT_MAX)) ? matches_reg + 1'b1
                                                              : matches_reg;
        rounds_next  = (rounds_reg != COUNT_MAX) ? rounds_reg + 1'b1 : rounds_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            seed_a_reg      <= SEED_RESET;
            seed_b_reg      <= SEED_RESET;
            mask_a_reg      <= MASK_RESET;
            mask_b_reg      <= MASK_RESET;
            round_total_reg <= ROUND_TOTAL_RESET;
            matches_reg     <= '0;
            rounds_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SEED_A:        seed_a_reg      <= cfg_wdata[VALUE_W-1:0];
                    CFG_SEED_B:        seed_b_reg      <= cfg_wdata[VALUE_W-1:0];
                    CFG_FILTER_MASK_A: mask_a_reg      <= cfg_wdata[MASK_W-1:0];
                    CFG_FILTER_MASK_B: mask_b_reg      <= cfg_wdata[MASK_W-1:0];
                    CFG_ROUND_TOTAL:   round_total_reg <= cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && !round_end) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_take) begin
                        if (s_restart) begin
                            matches_reg <= '0;
                            rounds_reg  <= '0;
                        end
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (round_end) begin
                        matches_reg     <= matches_next;
                        rounds_reg      <= rounds_next;
                        m_valid_reg     <= 1'b1;
                        value_a_reg     <= value_a;
                        value_b_reg     <= value_b;
                        low_match_reg   <= match;
                        match_count_reg <= matches_next;
                        final_round_reg <= (rounds_next == round_total_reg);
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_a     = value_a_reg;
    assign m_value_b     = value_b_reg;
    assign m_low_match   = low_match_reg;
    assign m_match_count = match_count_reg;
    assign m_final_round = final_round_reg;

endmodule

>>> rtl/flpm_gen.sv
// One filtered Lehmer generator: bit-serial modular multiply by a constant,
// repeated until the value clears the filter mask. Depends on flpm_pkg.
`timescale 1ns / 1ps

module flpm_gen #(
    parameter logic [flpm_pkg::MULT_BITS-1:0] MULT = flpm_pkg::MULT_A
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  flpm_pkg::gen_ctrl_t           ctrl,
    input  logic [flpm_pkg::VALUE_W-1:0]  seed,
    input  logic [flpm_pkg::MASK_W-1:0]   mask,
    output logic                          idle,
    output logic [flpm_pkg::VALUE_W-1:0]  value
);
    import flpm_pkg::*;

    localparam int CNT_W = (MULT_BITS > 1) ? $clog2(MULT_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MULT_BITS - 1);

    typedef enum logic {ST_IDLE, ST_MUL} state_t;

    state_t               state_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [VALUE_W-1:0]   acc_reg;
    logic [MULT_BITS-1:0] mult_sh_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [VALUE_W-1:0]   acc_rot;
    logic [VALUE_W:0]     acc_sum;
    logic [VALUE_W-1:0]   acc_next;
    logic                 filter_hit;

    // Horner over multiplier bits, MSB first: acc = 2*acc + bit*value mod (2^31-1).
    // Doubling modulo a Mersenne prime is a rotate.
    always_comb begin
        acc_rot = {acc_reg[VALUE_W-2:0], acc_reg[VALUE_W-1]};
        acc_sum = {1'b0, acc_rot}
                + (mult_sh_reg[MULT_BITS-1] ? {1'b0, value_reg} : '0);
        if (acc_sum >= {1'b0, MODULUS}) begin
            acc_next = VALUE_W'(acc_sum - {1'b0, MODULUS});
        end else begin
            acc_next = acc_sum[VALUE_W-1:0];
        end
        filter_hit = ((acc_next[MASK_W-1:0] & mask) != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            value_reg <= load_seed(SEED_RESET);
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (ctrl.start) begin
                        if (ctrl.load) begin
                            value_reg <= load_seed(seed);
                        end
                        acc_reg     <= '0;
                        mult_sh_reg <= MULT;
                        cnt_reg     <= CNT_LAST;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (cnt_reg == '0) begin
                        value_reg   <= acc_next;
                        // step again from the rejected value
                        acc_reg     <= '0;
                        mult_sh_reg <= MULT;
                        cnt_reg     <= CNT_LAST;
                        if (!filter_hit) begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        acc_reg     <= acc_next;
                        mult_sh_reg <= mult_sh_reg << 1;
                        cnt_reg     <= cnt_reg - 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign idle  = (state_reg == ST_IDLE);
    assign value = value_reg;

endmodule

>>> rtl/flpm_checker.sv
// Port-level checks for the filtered Lehmer pair match counter, bound to the
// core top level. Depends on flpm_pkg.
`timescale 1ns / 1ps

module flpm_checker #(
    parameter int COMPARE_BITS = flpm_pkg::COMPARE_BITS_DEFAULT
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [flpm_pkg::VALUE_W-1:0]    m_value_a,
    input logic [flpm_pkg::VALUE_W-1:0]    m_value_b,
    input logic                            m_low_match,
    input logic [flpm_pkg::COUNT_W-1:0]    m_match_count
);
    import flpm_pkg::*;

    localparam logic [VALUE_W-1:0] CMP_MASK = VALUE_W'((64'd1 << COMPARE_BITS) - 64'd1);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_a) && $stable(m_value_b)
                                && $stable(m_match_count))
        else $error("stalled result changed");

    // the flag agrees with the values it reports
    a_match_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_low_match == (((m_value_a ^ m_value_b) & CMP_MASK) == '0)))
        else $error("low_match disagrees with values");

    // a residue never shows the modulus itself
    a_residue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value_a != MODULUS) && (m_value_b != MODULUS))
        else $error("generator value out of range");

    // one round at a time: an accepted item closes the input
    a_one_round: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input open while a round runs");

endmodule

bind filtered_lehmer_pair_match_counter_core flpm_checker #(
    .COMPARE_BITS(COMPARE_BITS)
) u_flpm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value_a     (m_value_a),
    .m_value_b     (m_value_b),
    .m_low_match   (m_low_match),
    .m_match_count (m_match_count)
);
